// ===== hdl/json_string_escaper_assert.svh =====
// Assertion macros shared by the escaper RTL.
// In synthesis both macros expand to nothing.
`ifndef JSON_STRING_ESCAPER_ASSERT_SVH
`define JSON_STRING_ESCAPER_ASSERT_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge out of reset
`define JSE_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// cons must hold whenever ante holds
`define JSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define JSE_ASSERT(label, clk, rst_n, expr)
`define JSE_ASSERT_IMP(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/jse_pkg.sv =====
package jse_pkg;

    // default depth of the command queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // characters used in escapes
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_U         = 8'h75;
    localparam logic [7:0] CHAR_B         = 8'h62;
    localparam logic [7:0] CHAR_F         = 8'h66;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_T         = 8'h74;

    // input beat
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_item_t;

    // output beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
    } out_item_t;

    // kinds of output unit
    typedef enum logic [1:0] {
        UNIT_PLAIN,   // one byte as is
        UNIT_PAIR,    // backslash and one character
        UNIT_UESC     // \u and four hex digits
    } unit_kind_t;

    typedef struct packed {
        unit_kind_t  kind;
        logic [15:0] value;
    } unit_t;

    // one classified input item: up to four output units
    localparam int MAX_UNITS = 4;

    typedef struct packed {
        logic                        end_flag;
        logic [2:0]                  n_units;
        unit_t [MAX_UNITS-1:0]       units;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

// ===== hdl/jse_front.sv =====
`include "json_string_escaper_assert.svh"

module jse_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  jse_pkg::in_item_t item,
    input  logic          escape_non_ascii,
    output logic          cmd_valid,
    output jse_pkg::cmd_t cmd
);
    import jse_pkg::*;

    // UTF-8 gather state
    logic [7:0]  held_reg [3];
    logic [7:0]  held_next [3];
    logic [1:0]  count_reg, count_next;
    logic [1:0]  need_reg, need_next;
    logic [20:0] cp_reg, cp_next;

    logic [7:0]  b;
    logic [20:0] cp_ext;
    logic [20:0] cp_off;
    logic        fresh;
    logic [2:0]  n;
    unit_t [MAX_UNITS-1:0] units;

    function automatic unit_t mk_unit(unit_kind_t kind, logic [15:0] value);
        unit_t u;
        u.kind  = kind;
        u.value = value;
        return u;
    endfunction

    assign b = item.in_byte;

    // classify one byte and build its unit list
    always_comb
    begin
        held_next  = held_reg;
        count_next = count_reg;
        need_next  = need_reg;
        cp_next    = cp_reg;
        cp_ext     = {cp_reg[14:0], b[5:0]};
        cp_off     = cp_ext - 21'h010000;
        fresh      = 1'b0;
        n          = 3'd0;
        units      = '0;

        if (count_reg != 2'd0 && need_reg != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                // continuation byte
                cp_next   = cp_ext;
                need_next = need_reg - 2'd1;
                if (need_next == 2'd0)
                begin
                    if (cp_ext > 21'h00FFFF)
                    begin
                        units[0] = mk_unit(UNIT_UESC, 16'hD800 | {5'd0, cp_off[20:10]});
                        units[1] = mk_unit(UNIT_UESC, 16'hDC00 | {6'd0, cp_off[9:0]});
                        n = 3'd2;
                    end
                    else
                    begin
                        units[0] = mk_unit(UNIT_UESC, cp_ext[15:0]);
                        n = 3'd1;
                    end
                    count_next = 2'd0;
                    need_next  = 2'd0;
                    cp_next    = '0;
                end
                else if (count_reg != 2'd3)
                begin
                    held_next[count_reg] = b;
                    count_next = count_reg + 2'd1;
                end
            end
            else
            begin
                // broken sequence: escape held bytes one by one
                for (int i = 0; i < 3; i++)
                begin
                    if (i < int'(count_reg))
                    begin
                        units[n[1:0]] = mk_unit(UNIT_UESC, {8'h00, held_reg[i]});
                        n = n + 3'd1;
                    end
                end
                count_next = 2'd0;
                need_next  = 2'd0;
                cp_next    = '0;
                fresh      = 1'b1;
            end
        end
        else
        begin
            count_next = 2'd0;
            need_next  = 2'd0;
            cp_next    = '0;
            fresh      = 1'b1;
        end

        // byte handled with nothing held
        if (fresh)
        begin
            case (b)
                CHAR_QUOTE:     begin units[n[1:0]] = mk_unit(UNIT_PAIR, {8'h00, CHAR_QUOTE}); n = n + 3'd1; end
                CHAR_BACKSLASH: begin units[n[1:0]] = mk_unit(UNIT_PAIR, {8'h00, CHAR_BACKSLASH}); n = n + 3'd1; end
                8'h08:          begin units[n[1:0]] = mk_unit(UNIT_PAIR, {8'h00, CHAR_B}); n = n + 3'd1; end
                8'h0C:          begin units[n[1:0]] = mk_unit(UNIT_PAIR, {8'h00, CHAR_F}); n = n + 3'd1; end
                8'h0A:          begin units[n[1:0]] = mk_unit(UNIT_PAIR, {8'h00, CHAR_N}); n = n + 3'd1; end
                8'h0D:          begin units[n[1:0]] = mk_unit(UNIT_PAIR, {8'h00, CHAR_R}); n = n + 3'd1; end
                8'h09:          begin units[n[1:0]] = mk_unit(UNIT_PAIR, {8'h00, CHAR_T}); n = n + 3'd1; end
                default:
                begin
                    if (b < 8'h20)
                    begin
                        units[n[1:0]] = mk_unit(UNIT_UESC, {8'h00, b});
                        n = n + 3'd1;
                    end
                    else if (b[7] == 1'b0 || !escape_non_ascii)
                    begin
                        units[n[1:0]] = mk_unit(UNIT_PLAIN, {8'h00, b});
                        n = n + 3'd1;
                    end
                    else if (b[7:5] == 3'b110)
                    begin
                        held_next[0] = b;
                        count_next   = 2'd1;
                        need_next    = 2'd1;
                        cp_next      = {16'd0, b[4:0]};
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        held_next[0] = b;
                        count_next   = 2'd1;
                        need_next    = 2'd2;
                        cp_next      = {17'd0, b[3:0]};
                    end
                    else if (b[7:3] == 5'b11110)
                    begin
                        held_next[0] = b;
                        count_next   = 2'd1;
                        need_next    = 2'd3;
                        cp_next      = {18'd0, b[2:0]};
                    end
                    else
                    begin
                        units[n[1:0]] = mk_unit(UNIT_UESC, {8'h00, b});
                        n = n + 3'd1;
                    end
                end
            endcase
        end

        // end of string flushes what is still held
        if (item.end_of_string)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (i < int'(count_next))
                begin
                    units[n[1:0]] = mk_unit(UNIT_UESC, {8'h00, held_next[i]});
                    n = n + 3'd1;
                end
            end
            count_next = 2'd0;
            need_next  = 2'd0;
            cp_next    = '0;
        end
    end

    assign cmd_valid    = accept && (n != 3'd0);
    assign cmd.end_flag = item.end_of_string;
    assign cmd.n_units  = n;
    assign cmd.units    = units;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            need_reg  <= 2'd0;
            cp_reg    <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            need_reg  <= need_next;
            cp_reg    <= cp_next;
        end
    end

    // held bytes, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

    `JSE_ASSERT_IMP(a_need_has_held, clk, rst_n, need_reg != 2'd0, count_reg != 2'd0)
    `JSE_ASSERT(a_seq_len, clk, rst_n, ({1'b0, count_reg} + {1'b0, need_reg}) <= 3'd4)
    `JSE_ASSERT_IMP(a_end_pushes, clk, rst_n, accept && item.end_of_string, cmd_valid)

endmodule

// ===== hdl/jse_fifo.sv =====
`include "json_string_escaper_assert.svh"

module jse_fifo
#(
    parameter int DEPTH = jse_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  jse_pkg::cmd_t        wr_data,
    input  logic                 rd_en,
    output jse_pkg::cmd_t        rd_data,
    output jse_pkg::fifo_status_t status
);
    import jse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data      = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    `JSE_ASSERT(a_count_range, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `JSE_ASSERT_IMP(a_no_overflow, clk, rst_n, wr_en, !status.full)
    `JSE_ASSERT_IMP(a_no_underflow, clk, rst_n, rd_en, !status.empty)

endmodule

// ===== hdl/jse_back.sv =====
`include "json_string_escaper_assert.svh"

module jse_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  jse_pkg::cmd_t         head,
    input  jse_pkg::fifo_status_t q_status,
    output logic                  q_rd,
    output logic                  empty,
    input  logic                  pop,
    output jse_pkg::out_item_t    out_item
);
    import jse_pkg::*;

    logic [1:0]  unit_idx_reg, unit_idx_next;
    logic [2:0]  byte_idx_reg, byte_idx_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg;

    unit_t       cur;
    logic [7:0]  cur_byte;
    logic [2:0]  unit_len;
    logic        last_byte;
    logic        last_unit;
    logic        advance;

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'd0, nib};
        end
        else
        begin
            c = 8'h57 + {4'd0, nib};
        end
        return c;
    endfunction

    assign cur = head.units[unit_idx_reg];

    // byte generator for the current unit
    always_comb
    begin
        cur_byte = CHAR_BACKSLASH;
        unit_len = 3'd1;
        case (cur.kind)
            UNIT_PLAIN:
            begin
                unit_len = 3'd1;
                cur_byte = cur.value[7:0];
            end
            UNIT_PAIR:
            begin
                unit_len = 3'd2;
                cur_byte = (byte_idx_reg == 3'd0) ? CHAR_BACKSLASH : cur.value[7:0];
            end
            UNIT_UESC:
            begin
                unit_len = 3'd6;
                case (byte_idx_reg)
                    3'd0:    cur_byte = CHAR_BACKSLASH;
                    3'd1:    cur_byte = CHAR_U;
                    3'd2:    cur_byte = hex_char(cur.value[15:12]);
                    3'd3:    cur_byte = hex_char(cur.value[11:8]);
                    3'd4:    cur_byte = hex_char(cur.value[7:4]);
                    default: cur_byte = hex_char(cur.value[3:0]);
                endcase
            end
            default:
            begin
                unit_len = 3'd1;
                cur_byte = cur.value[7:0];
            end
        endcase
    end

    assign last_byte = (byte_idx_reg == unit_len - 3'd1);
    assign last_unit = ({1'b0, unit_idx_reg} == head.n_units - 3'd1);
    assign advance   = !q_status.empty && (!out_valid_reg || pop);
    assign q_rd      = advance && last_byte && last_unit;

    // sequencer
    always_comb
    begin
        unit_idx_next  = unit_idx_reg;
        byte_idx_next  = byte_idx_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (last_byte)
            begin
                byte_idx_next = 3'd0;
                unit_idx_next = last_unit ? 2'd0 : unit_idx_reg + 2'd1;
            end
            else
            begin
                byte_idx_next = byte_idx_reg + 3'd1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_idx_reg  <= 2'd0;
            byte_idx_reg  <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unit_idx_reg  <= unit_idx_next;
            byte_idx_reg  <= byte_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.out_byte    <= cur_byte;
            out_reg.run_last    <= last_byte && last_unit;
            out_reg.string_done <= last_byte && last_unit && head.end_flag;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    `JSE_ASSERT_IMP(a_done_is_last, clk, rst_n, out_valid_reg && out_reg.string_done,
                    out_reg.run_last)
    `JSE_ASSERT_IMP(a_unit_in_range, clk, rst_n, !q_status.empty,
                    {1'b0, unit_idx_reg} < head.n_units)
    `JSE_ASSERT_IMP(a_byte_in_range, clk, rst_n, !q_status.empty, byte_idx_reg < unit_len)

endmodule

// ===== hdl/json_string_escaper.sv =====
// An input beat's first result passes the command queue, then the output beat register.
// Throughput: one output byte per cycle unless the queue is empty or the output waits for
// pop; an item yields 0 to 24 bytes at the back end (0 for a byte that only extends a held
// sequence, 1 for plain text, 2 for short escapes, 6 per \uxxxx escape, 12 for a surrogate
// pair). The front takes a new item every cycle while the command queue has room.
// Async active-low rst_n clears gather counts, queue pointers, output valid and config reg.

module json_string_escaper
#(
    parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               push,
    output logic               full,
    input  jse_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output jse_pkg::out_item_t out_item
);
    import jse_pkg::*;

    logic         escape_non_ascii_reg;
    logic         accept;
    logic         cmd_valid;
    cmd_t         cmd;
    cmd_t         head;
    fifo_status_t q_status;
    logic         q_rd;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_non_ascii_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            escape_non_ascii_reg <= cfg_wdata;
        end
    end

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    jse_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .item             (in_item),
        .escape_non_ascii (escape_non_ascii_reg),
        .cmd_valid        (cmd_valid),
        .cmd              (cmd)
    );

    jse_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_data (cmd),
        .rd_en   (q_rd),
        .rd_data (head),
        .status  (q_status)
    );

    jse_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .q_rd     (q_rd),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule
